// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the IMU frame decoder RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// Condition must never be seen at a clock edge outside reset.
`define ASSERT_NEVER(name, clk, rst, cond) \
   name: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition seen");

`endif

// ----- rtl/ifrd_pkg.sv -----
// ----------------------------------------------------------------------------
// ifrd_pkg
// Types and constants shared by the IMU frame receiver/decoder modules.
// ----------------------------------------------------------------------------
package ifrd_pkg;

   localparam int unsigned FrameLen = 11;
   localparam int unsigned PosW     = 4;

   localparam logic [7:0] HdrByte   = 8'h55;
   localparam logic [7:0] TypeAcc   = 8'h51;
   localparam logic [7:0] TypeRate  = 8'h52;
   localparam logic [7:0] TypeAngle = 8'h53;

   // temperature: floor(t*64/85) + 9280
   // m = t*64 + 85*24673 is never negative and fits 22 bits,
   // floor(m/85) = (m * ceil(2^29/85)) >> 29 exactly for m < 2^22.
   localparam int unsigned TempMW    = 22;
   localparam int unsigned TempShift = 29;
   localparam logic [22:0] TempRecip = 23'd6316129;
   localparam logic [22:0] TempBias  = 23'd2097205;   // 85 * 24673
   localparam logic signed [16:0] TempOfs = 17'sd15393; // 24673 - 9280

   typedef enum logic [1:0] {
      KIND_ACC   = 2'd0,
      KIND_RATE  = 2'd1,
      KIND_ANGLE = 2'd2,
      KIND_OTHER = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type           kind;
      logic signed [15:0] raw_x;
      logic signed [15:0] raw_y;
      logic signed [15:0] raw_z;
      logic signed [15:0] raw_t;
   } raw_frame_type;

   localparam int unsigned RawFrameW = $bits(raw_frame_type);

endpackage

// ----- rtl/ifrd_front.sv -----
// ----------------------------------------------------------------------------
// ifrd_front
// Header hunt and frame collection; classifies the type byte and pushes
// one raw frame to the queue on the eleventh byte.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ifrd_front (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [7:0]                     req_tdata,
   input  logic                           q_full,
   output logic                           q_push,
   output ifrd_pkg::raw_frame_type        q_wdata
);
   import ifrd_pkg::*;

   logic [PosW-1:0] pos_ff, pos_in, pos_eff;
   logic [7:0]      frame_ff [1:FrameLen-2];
   logic            accept, last_byte;
   kind_type        kind;

   // a position past the frame end reads as zero
   assign pos_eff   = (pos_ff >= PosW'(FrameLen)) ? '0 : pos_ff;
   assign last_byte = (pos_eff == PosW'(FrameLen - 1));
   // only the closing beat needs queue space
   assign req_tready = !(last_byte && q_full);
   assign accept     = req_tvalid && req_tready;
   assign q_push     = accept && last_byte;

   always_comb begin
      pos_in = pos_eff;
      if (accept) begin
         if (pos_eff == '0 && req_tdata != HdrByte) begin
            pos_in = '0;
         end else if (last_byte) begin
            pos_in = '0;
         end else begin
            pos_in = pos_eff + PosW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else begin
         pos_ff <= pos_in;
      end
   end

   // header and checksum bytes are not kept
   always_ff @(posedge clock) begin
      for (int i = 1; i <= FrameLen - 2; i++) begin
         if (accept && pos_eff == PosW'(i)) begin
            frame_ff[i] <= req_tdata;
         end
      end
   end

   always_comb begin
      unique case (frame_ff[1])
         TypeAcc:   kind = KIND_ACC;
         TypeRate:  kind = KIND_RATE;
         TypeAngle: kind = KIND_ANGLE;
         default:   kind = KIND_OTHER;
      endcase
   end

   assign q_wdata.kind  = kind;
   assign q_wdata.raw_x = {frame_ff[3], frame_ff[2]};
   assign q_wdata.raw_y = {frame_ff[5], frame_ff[4]};
   assign q_wdata.raw_z = {frame_ff[7], frame_ff[6]};
   assign q_wdata.raw_t = {frame_ff[9], frame_ff[8]};

   `ASSERT_CLK(a_pos_range, clock, reset, pos_ff <= PosW'(FrameLen - 1))

endmodule

// ----- rtl/ifrd_queue.sv -----
// ----------------------------------------------------------------------------
// ifrd_queue
// Small FIFO of raw frames between the front and back ends.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ifrd_queue #(
   parameter int unsigned Depth = 2
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  ifrd_pkg::raw_frame_type wdata,
   output logic                    full,
   input  logic                    pop,
   output logic                    rvalid,
   output ifrd_pkg::raw_frame_type rdata
);
   import ifrd_pkg::*;

   localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int unsigned CntW = $clog2(Depth + 1);

   raw_frame_type   mem_ff [Depth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;
   logic            do_push, do_pop;

   assign full    = (count_ff == CntW'(Depth));
   assign rvalid  = (count_ff != '0);
   assign rdata   = mem_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && rvalid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + PtrW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + PtrW'(1);
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + CntW'(1);
         2'b01:   count_in = count_ff - CntW'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

   `ASSERT_NEVER(a_push_full, clock, reset, push && full)
   `ASSERT_CLK(a_count_range, clock, reset, count_ff <= CntW'(Depth))

endmodule

// ----- rtl/ifrd_back.sv -----
// ----------------------------------------------------------------------------
// ifrd_back
// Two-stage scaling pipeline: multiply, then shift/offset into the
// output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ifrd_back (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    q_valid,
   input  ifrd_pkg::raw_frame_type q_rdata,
   output logic                    q_pop,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [79:0]             rsp_tdata,
   output logic [1:0]              rsp_tuser
);
   import ifrd_pkg::*;

   logic                  advance;
   logic [7:0]            coef;
   logic signed [15:0]    raw [3];

   // stage 1: products
   logic                  s1_valid_ff;
   kind_type              s1_kind_ff;
   logic signed [23:0]    s1_prod_ff [3];
   logic [15:0]           s1_tq_ff;
   logic signed [23:0]    prod_in [3];
   logic [TempMW-1:0]     temp_m;
   logic [22:0]           temp_sum;
   logic [TempMW+22:0]    temp_prod;

   // stage 2: output register
   logic                  out_valid_ff;
   kind_type              out_kind_ff;
   logic signed [19:0]    out_axis_ff [3];
   logic signed [16:0]    out_temp_ff;
   logic signed [19:0]    axis_in [3];
   logic signed [16:0]    temp_in;

   assign advance = !out_valid_ff || rsp_tready;
   assign q_pop   = advance && q_valid;

   assign raw[0] = q_rdata.raw_x;
   assign raw[1] = q_rdata.raw_y;
   assign raw[2] = q_rdata.raw_z;

   // a zero coefficient makes the axes of unknown frames read as zero
   always_comb begin
      unique case (q_rdata.kind)
         KIND_ACC:   coef = 8'd1;
         KIND_RATE:  coef = 8'd125;
         KIND_ANGLE: coef = 8'd45;
         default:    coef = 8'd0;
      endcase
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         prod_in[i] = 24'(raw[i]) * $signed({16'd0, coef});
      end
   end

   assign temp_sum  = 23'($signed({q_rdata.raw_t, 6'd0})) + TempBias;
   assign temp_m    = temp_sum[TempMW-1:0];
   assign temp_prod = 45'(temp_m) * 45'(TempRecip);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= q_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_kind_ff <= q_rdata.kind;
         s1_tq_ff   <= temp_prod[TempShift +: 16];
         for (int i = 0; i < 3; i++) begin
            s1_prod_ff[i] <= prod_in[i];
         end
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (s1_kind_ff == KIND_ANGLE) begin
            axis_in[i] = 20'(s1_prod_ff[i] >>> 5);
         end else begin
            axis_in[i] = 20'(s1_prod_ff[i] >>> 3);
         end
      end
      if (s1_kind_ff == KIND_OTHER) begin
         temp_in = '0;
      end else begin
         temp_in = $signed({1'b0, s1_tq_ff}) - TempOfs;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_kind_ff <= s1_kind_ff;
         out_temp_ff <= temp_in;
         for (int i = 0; i < 3; i++) begin
            out_axis_ff[i] <= axis_in[i];
         end
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_kind_ff;
   assign rsp_tdata  = {3'd0, out_temp_ff, out_axis_ff[2], out_axis_ff[1], out_axis_ff[0]};

   `ASSERT_CLK(a_other_zero, clock, reset,
      (out_valid_ff && out_kind_ff == KIND_OTHER) |-> (rsp_tdata == '0))
   `ASSERT_CLK(a_stage_move, clock, reset,
      (s1_valid_ff && advance) |=> out_valid_ff)

endmodule

// ----- rtl/imu_frame_receiver_decoder.sv -----
// ----------------------------------------------------------------------------
// imu_frame_receiver_decoder
// Serial IMU frame parser: 11-byte frames in, one scaled record per frame.
// ----------------------------------------------------------------------------
// Takes one received serial byte per beat, one beat per clock while req_tready is high.
// Bytes are dropped until a 0x55 header; the header and the next ten bytes
// form a frame (0x55 inside a frame is plain data, the checksum is ignored).
// Each frame yields one record on rsp: tuser is the frame kind
// (0 accel, 1 rate, 2 angle, 3 unknown type), tdata holds X/Y/Z and
// temperature in signed fixed point with 8 fraction bits, floored. Unknown
// frames give all-zero values. After the edge that takes a frame's last byte,
// the record passes the queue write on that edge, then the multiply stage,
// then the output register, where rsp_tvalid rises; an rsp stall can hold it.
// req_tready drops only on a frame's last byte while the frame queue is
// full; the queue depth, plus up to two records held in the back end, sets
// how many records can pile up behind a stalled rsp before the input stalls.
// ----------------------------------------------------------------------------
module imu_frame_receiver_decoder #(
   parameter int unsigned QUEUE_DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   // input beats: serial bytes
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   // result beats: decoded records
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [79:0] rsp_tdata,   // [19:0] axis_x, [39:20] axis_y, [59:40] axis_z,
                                    // [76:60] temperature, [79:77] zero
   output logic [1:0]  rsp_tuser    // [1:0] frame_kind
);
   import ifrd_pkg::*;

   logic          q_push, q_full, q_pop, q_valid;
   raw_frame_type q_wdata, q_rdata;

   // front: header hunt, byte collection, type classification
   ifrd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_wdata    (q_wdata)
   );

   // decouples the byte side from a stalled result side
   ifrd_queue #(
      .Depth (QUEUE_DEPTH)
   ) u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (q_push),
      .wdata  (q_wdata),
      .full   (q_full),
      .pop    (q_pop),
      .rvalid (q_valid),
      .rdata  (q_rdata)
   );

   // back: scaling pipeline and output register
   ifrd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_rdata    (q_rdata),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the IMU frame receiver/decoder: streams serial bytes
// (directed extremes, then random frames mixed with line noise), predicts every
// decoded record and compares it field by field against the rsp beats.
// ----------------------------------------------------------------------------
import ifrd_pkg::*;

typedef struct packed {
   kind_type    kind;
   logic [19:0] axis_x;
   logic [19:0] axis_y;
   logic [19:0] axis_z;
   logic [16:0] temp;
} imu_record_type;

// Frame decoder model plus the queue of records still owed by the DUT.
class imu_record_scoreboard;
   logic [3:0]     frame_pos;
   logic [7:0]     frame_buf [11];
   imu_record_type owed[$];
   int unsigned    mismatches;

   function new();
      frame_pos  = '0;
      mismatches = 0;
   endfunction

   static function longint floor_div(longint num, longint den);
      longint q;
      q = num / den;
      if ((num % den) != 0 && num < 0) q = q - 1;
      return q;
   endfunction

   function longint raw_word(int lo);
      logic signed [15:0] w;
      w = {frame_buf[lo + 1], frame_buf[lo]};
      return longint'(w);
   endfunction

   static function longint scale_axis(kind_type k, longint r);
      case (k)
         KIND_ACC:   return floor_div(r, 8);
         KIND_RATE:  return floor_div(r * 125, 8);
         KIND_ANGLE: return floor_div(r * 45, 32);
         default:    return 0;
      endcase
   endfunction

   // One accepted serial byte; pushes a record when it closes a frame.
   function void note_byte(logic [7:0] b);
      imu_record_type rec;
      longint         t;
      if (frame_pos > 4'd10) frame_pos = '0;
      if (frame_pos == 4'd0 && b != HdrByte) return;
      frame_buf[frame_pos] = b;
      frame_pos = frame_pos + 4'd1;
      if (frame_pos < 4'd11) return;
      frame_pos = '0;
      case (frame_buf[1])
         TypeAcc:   rec.kind = KIND_ACC;
         TypeRate:  rec.kind = KIND_RATE;
         TypeAngle: rec.kind = KIND_ANGLE;
         default:   rec.kind = KIND_OTHER;
      endcase
      rec.axis_x = 20'(scale_axis(rec.kind, raw_word(2)));
      rec.axis_y = 20'(scale_axis(rec.kind, raw_word(4)));
      rec.axis_z = 20'(scale_axis(rec.kind, raw_word(6)));
      t = (rec.kind == KIND_OTHER) ? 0 : floor_div(raw_word(8) * 64, 85) + 9280;
      rec.temp = 17'(t);
      owed.push_back(rec);
   endfunction

   // One accepted rsp beat against the oldest owed record.
   function void check_record(logic [1:0] kind, logic [79:0] data);
      imu_record_type exp_rec;
      bit             bad;
      if (owed.size() == 0) begin
         if (mismatches < 10)
            $display("[%0t] record with none owed: kind=%0d data=%h", $time, kind, data);
         mismatches++;
         return;
      end
      exp_rec = owed.pop_front();
      bad = (kind !== exp_rec.kind) || (data[19:0] !== exp_rec.axis_x) ||
            (data[39:20] !== exp_rec.axis_y) || (data[59:40] !== exp_rec.axis_z) ||
            (data[76:60] !== exp_rec.temp) || (data[79:77] !== 3'b000);
      if (bad) begin
         if (mismatches < 10) begin
            $display("[%0t] record mismatch", $time);
            $display("   exp kind=%0d x=%0d y=%0d z=%0d temp=%0d pad=0", exp_rec.kind,
                     $signed(exp_rec.axis_x), $signed(exp_rec.axis_y),
                     $signed(exp_rec.axis_z), $signed(exp_rec.temp));
            $display("   got kind=%0d x=%0d y=%0d z=%0d temp=%0d pad=%0d", kind,
                     $signed(data[19:0]), $signed(data[39:20]), $signed(data[59:40]),
                     $signed(data[76:60]), data[79:77]);
         end
         mismatches++;
      end
   endfunction
endclass

module tb_top;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'h00;   // [7:0] rx_byte
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [79:0] rsp_tdata;            // [19:0] x, [39:20] y, [59:40] z, [76:60] temp
   logic [1:0]  rsp_tuser;            // [1:0] frame_kind

   // calm: both sides stop idling; hold_go: receiver does its one long stall
   bit          calm       = 1'b0;
   bit          hold_go    = 1'b0;
   int unsigned bytes_sent = 0;

   imu_record_scoreboard sb = new();

   imu_frame_receiver_decoder dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Monitors: sample both channels at the edge the beat is taken.
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) sb.note_byte(req_tdata);
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_record(rsp_tuser, rsp_tdata);
   end

   // Receiver: ~18% random stall, none while calm, and one long hold-off
   // (counted here) so the record queue fills and req_tready drops.
   initial begin : receiver
      int  hold_left;
      bit  hold_done;
      hold_left = 0;
      hold_done = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_go && !hold_done) begin
            hold_left = 150;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else begin
            rsp_tready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 18);
         end
      end
   end

   // One serial byte; returns right after the edge that takes it.
   // Idle cycles come one at a time with 18% odds each, so ~18% of cycles idle.
   task automatic send_byte(input logic [7:0] b);
      if (!calm) begin
         while ($urandom_range(0, 99) < 18) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      bytes_sent++;
   endtask

   task automatic send_frame(input logic [7:0] type_byte, input logic [15:0] x,
                             input logic [15:0] y, input logic [15:0] z,
                             input logic [15:0] t, input logic [7:0] chk);
      send_byte(HdrByte);
      send_byte(type_byte);
      send_byte(x[7:0]); send_byte(x[15:8]);
      send_byte(y[7:0]); send_byte(y[15:8]);
      send_byte(z[7:0]); send_byte(z[15:8]);
      send_byte(t[7:0]); send_byte(t[15:8]);
      send_byte(chk);
   endtask

   // Raw 16-bit word, biased toward the signed extremes and zero.
   function automatic logic [15:0] pick_word();
      case ($urandom_range(0, 11))
         0:       return 16'h7FFF;
         1:       return 16'h8000;
         2:       return 16'hFFFF;
         3:       return 16'h0000;
         default: return 16'($urandom());
      endcase
   endfunction

   function automatic logic [7:0] pick_type();
      if ($urandom_range(0, 99) < 85) return 8'(TypeAcc + $urandom_range(0, 2));
      return 8'($urandom_range(0, 255));
   endfunction

   initial begin : stimulus
      int unsigned frame_cnt;
      int unsigned rand_start;
      frame_cnt = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: line noise ahead of the first header, then one frame per
      // kind with the axis and temperature extremes. The accel frame carries
      // the header value as checksum data; the unknown frame has it as type.
      send_byte(8'h00);
      send_byte(8'hFF);
      send_frame(TypeAcc,   16'h7FFF, 16'h8000, 16'hFFFF, 16'h7FFF, HdrByte);
      send_frame(TypeRate,  16'h8000, 16'h7FFF, 16'h0001, 16'h8000, 8'h00);
      send_frame(TypeAngle, 16'hFFFF, 16'h0000, 16'h7FFF, 16'h0000, 8'hAA);
      send_frame(HdrByte,   16'h1234, 16'h8000, 16'h7FFF, 16'h7FFF, 8'hFF);

      // Random: mostly clean frames with random payload, some noise bursts
      // that can shift framing (a stray header opens a frame mid-stream).
      rand_start = bytes_sent;
      hold_go <= 1'b1;
      while (bytes_sent - rand_start < 600) begin
         calm = (frame_cnt >= 20 && frame_cnt < 32);
         if ($urandom_range(0, 99) < 82) begin
            send_frame(pick_type(), pick_word(), pick_word(), pick_word(), pick_word(),
                       8'($urandom_range(0, 255)));
            frame_cnt++;
         end else begin
            repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
         end
      end
      calm = 1'b0;
      req_tvalid <= 1'b0;

      // drain, then keep watching past the pipe for stray records
      while (sb.owed.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (sb.mismatches == 0 && sb.owed.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

   // Run limit, far above the slowest legal run.
   initial begin : watchdog
      #2000000;
      $display("TB_ERROR");
      $finish;
   end

endmodule
